FILE: design/radial_gradient_circle_pixel_macros.svh
// Assertion macros for the radial gradient disc checker.
// Depends on nothing; expects clk_i and rst_ni in the scope where it is used.
`ifndef RADIAL_GRADIENT_CIRCLE_PIXEL_MACROS_SVH
`define RADIAL_GRADIENT_CIRCLE_PIXEL_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RGCP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RGCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rgcp_pkg.sv
// Shared widths, types and step functions of the radial gradient disc.
// Used by every module of the block; depends on nothing.
package rgcp_pkg;

  localparam int unsigned CoordW       = 9;
  localparam int unsigned ColorW       = 8;
  localparam int unsigned RadiusW      = 8;
  localparam int unsigned FracW        = 10;
  localparam int unsigned TW           = FracW + 1;
  localparam int unsigned UnitT        = 1 << FracW;
  localparam int unsigned D2W          = 2 * RadiusW;
  localparam int unsigned SqW          = 2 * CoordW;
  localparam int unsigned SumW         = SqW + 1;
  localparam int unsigned RootW        = RadiusW + FracW;
  localparam int unsigned RemW         = RootW + 2;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned RootSteps    = RootW;
  localparam int unsigned RootStages   = (RootSteps + StepsPerStage - 1) / StepsPerStage;
  localparam int unsigned DivSteps     = TW;
  localparam int unsigned DivStages    = (DivSteps + StepsPerStage - 1) / StepsPerStage;
  localparam int unsigned ProdW        = ColorW + TW;
  localparam int unsigned NumChan      = 3;
  localparam int unsigned ChRed        = 0;
  localparam int unsigned ChGreen      = 1;
  localparam int unsigned ChBlue       = 2;
  localparam int unsigned AlphaMax     = 255;
  localparam int unsigned MaxRadiusDef = 255;
  localparam int unsigned CfgIdxW      = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRadius     = 3'd0,
    CfgStartRed   = 3'd1,
    CfgEndRed     = 3'd2,
    CfgStartGreen = 3'd3,
    CfgEndGreen   = 3'd4,
    CfgStartBlue  = 3'd5,
    CfgEndBlue    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic           in_disc;
    logic [D2W-1:0] d2;
  } rgcp_dist_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } rgcp_sqrt_t;

  typedef struct packed {
    logic             in_disc;
    logic [RootW-1:0] root;
  } rgcp_root_t;

  typedef struct packed {
    logic [RadiusW-1:0] rem;
    logic [TW-1:0]      quo;
  } rgcp_divw_t;

  typedef struct packed {
    logic          in_disc;
    logic [TW-1:0] t;
  } rgcp_ratio_t;

  typedef struct packed {
    logic [ColorW-1:0] start;
    logic [ColorW-1:0] stop;
  } rgcp_ramp_t;

  typedef struct packed {
    logic                           in_disc;
    logic [NumChan-1:0][ColorW-1:0] color;
    logic [ColorW-1:0]              alpha;
  } rgcp_pix_t;

  // One digit of the restoring square root: two radicand bits in, one root bit out.
  function automatic rgcp_sqrt_t sqrt_step(input rgcp_sqrt_t cur, input logic [1:0] pair);
    logic [RemW+1:0] trial;
    logic [RemW+1:0] cand;
    rgcp_sqrt_t      nxt;
    trial = {cur.rem, pair};
    cand  = (RemW + 2)'({cur.root, 2'b01});
    if (trial >= cand) begin
      nxt.rem  = RemW'(trial - cand);
      nxt.root = {cur.root[RootW-2:0], 1'b1};
    end else begin
      nxt.rem  = RemW'(trial);
      nxt.root = {cur.root[RootW-2:0], 1'b0};
    end
    return nxt;
  endfunction

  // One quotient bit of the restoring divide by the radius.
  function automatic rgcp_divw_t div_step(input rgcp_divw_t cur, input logic dbit,
                                          input logic [RadiusW-1:0] divisor);
    logic [RadiusW:0] trial;
    rgcp_divw_t       nxt;
    trial = {cur.rem, dbit};
    if (trial >= {1'b0, divisor}) begin
      nxt.rem = RadiusW'(trial - {1'b0, divisor});
      nxt.quo = {cur.quo[TW-2:0], 1'b1};
    end else begin
      nxt.rem = RadiusW'(trial);
      nxt.quo = {cur.quo[TW-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

FILE: design/radial_gradient_circle_pixel.sv
// Radial gradient disc. One pixel coordinate enters per clock and one RGBA result leaves per
// clock while no stall holds; each result passes through 20 pipeline stages and
// an output register. The depth is set by the 18-bit square root and the 11-bit divide by the
// radius, each worked at most two bits per stage. The output register has a one-entry skid behind it,
// so input transfers continue while a result waits; in_stall_o rises only once that skid holds
// an item. Configuration writes are taken in any cycle but must only occur while the pipeline
// is empty. Depends on rgcp_pkg and the rgcp_dist, rgcp_sqrt, rgcp_div and rgcp_shade modules.
module radial_gradient_circle_pixel #(
  parameter int unsigned MAX_RADIUS = rgcp_pkg::MaxRadiusDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rgcp_pkg::CoordW-1:0]  pixel_x_i,
  input  logic [rgcp_pkg::CoordW-1:0]  pixel_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         inside_res_o,
  output logic [rgcp_pkg::ColorW-1:0]  red_out_o,
  output logic [rgcp_pkg::ColorW-1:0]  green_out_o,
  output logic [rgcp_pkg::ColorW-1:0]  blue_out_o,
  output logic [rgcp_pkg::ColorW-1:0]  alpha_out_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rgcp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rgcp_pkg::ColorW-1:0]  cfg_data_i
);
  import rgcp_pkg::*;

  logic [RadiusW-1:0]            radius_q;
  logic [ColorW-1:0]             start_red_q, end_red_q;
  logic [ColorW-1:0]             start_green_q, end_green_q;
  logic [ColorW-1:0]             start_blue_q, end_blue_q;
  logic [RadiusW-1:0]            radius_eff;
  rgcp_ramp_t [NumChan-1:0]      ramps;
  logic                          en;
  logic                          dist_valid, root_valid, ratio_valid, pipe_valid;
  rgcp_dist_t                    dist_data;
  rgcp_root_t                    root;
  rgcp_ratio_t                   ratio;
  rgcp_pix_t                     pipe_pix;
  logic                          out_valid_d, out_valid_q;
  logic                          skid_valid_d, skid_valid_q;
  logic                          load_out, load_skid;
  rgcp_pix_t                     out_pix_q, skid_pix_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q      <= RadiusW'(1);
      start_red_q   <= '0;
      end_red_q     <= '0;
      start_green_q <= '0;
      end_green_q   <= '0;
      start_blue_q  <= '0;
      end_blue_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgRadius:     radius_q      <= cfg_data_i;
        CfgStartRed:   start_red_q   <= cfg_data_i;
        CfgEndRed:     end_red_q     <= cfg_data_i;
        CfgStartGreen: start_green_q <= cfg_data_i;
        CfgEndGreen:   end_green_q   <= cfg_data_i;
        CfgStartBlue:  start_blue_q  <= cfg_data_i;
        CfgEndBlue:    end_blue_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign radius_eff = (int'(radius_q) > MAX_RADIUS) ? RadiusW'(MAX_RADIUS) : radius_q;

  assign ramps[ChRed]   = '{start: start_red_q,   stop: end_red_q};
  assign ramps[ChGreen] = '{start: start_green_q, stop: end_green_q};
  assign ramps[ChBlue]  = '{start: start_blue_q,  stop: end_blue_q};

  // The pipeline only freezes while the skid entry is occupied.
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  rgcp_dist u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .radius_i  (radius_eff),
    .valid_o   (dist_valid),
    .dist_o    (dist_data)
  );

  rgcp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dist_valid),
    .dist_i  (dist_data),
    .valid_o (root_valid),
    .root_o  (root)
  );

  rgcp_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (root_valid),
    .root_i   (root),
    .radius_i (radius_eff),
    .valid_o  (ratio_valid),
    .ratio_o  (ratio)
  );

  rgcp_shade u_shade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ratio_valid),
    .ratio_i (ratio),
    .ramp_i  (ramps),
    .valid_o (pipe_valid),
    .pix_o   (pipe_pix)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
        load_out     = 1'b1;
      end else begin
        out_valid_d = pipe_valid;
        load_out    = pipe_valid;
      end
    end else if (pipe_valid && en) begin
      skid_valid_d = 1'b1;
      load_skid    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_pix_q <= skid_valid_q ? skid_pix_q : pipe_pix;
    end
    if (load_skid) begin
      skid_pix_q <= pipe_pix;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = out_pix_q.in_disc;
  assign red_out_o    = out_pix_q.color[ChRed];
  assign green_out_o  = out_pix_q.color[ChGreen];
  assign blue_out_o   = out_pix_q.color[ChBlue];
  assign alpha_out_o  = out_pix_q.alpha;

endmodule

FILE: design/rgcp_dist.sv
// Three-stage front end: offsets from the center, squares, and the inside test.
// Depends on rgcp_pkg.
module rgcp_dist (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [rgcp_pkg::CoordW-1:0]  pixel_x_i,
  input  logic [rgcp_pkg::CoordW-1:0]  pixel_y_i,
  input  logic [rgcp_pkg::RadiusW-1:0] radius_i,
  output logic                         valid_o,
  output rgcp_pkg::rgcp_dist_t         dist_o
);
  import rgcp_pkg::*;

  logic [CoordW-1:0] r_ext;
  logic [CoordW-1:0] span;
  logic [CoordW-1:0] dx_d, dy_d, dx_q, dy_q;
  logic              oob_d, oob1_q, oob2_q;
  logic              valid1_q, valid2_q, valid3_q;
  logic [SqW-1:0]    sqx_d, sqy_d, sqx_q, sqy_q;
  logic [D2W-1:0]    rr_d, rr_q;
  logic [SumW-1:0]   sum_d;
  rgcp_dist_t        dist_d, dist_q;

  assign r_ext = CoordW'(radius_i);
  assign span  = CoordW'({radius_i, 1'b0});
  assign dx_d  = (pixel_x_i >= r_ext) ? pixel_x_i - r_ext : r_ext - pixel_x_i;
  assign dy_d  = (pixel_y_i >= r_ext) ? pixel_y_i - r_ext : r_ext - pixel_y_i;
  assign oob_d = (radius_i == '0) || (pixel_x_i >= span) || (pixel_y_i >= span);

  assign sqx_d = SqW'(dx_q) * SqW'(dx_q);
  assign sqy_d = SqW'(dy_q) * SqW'(dy_q);
  assign rr_d  = D2W'(radius_i) * D2W'(radius_i);

  assign sum_d          = SumW'(sqx_q) + SumW'(sqy_q);
  assign dist_d.in_disc = !oob2_q && (sum_d <= SumW'(rr_q));
  assign dist_d.d2      = sum_d[D2W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      oob1_q <= oob_d;
      sqx_q  <= sqx_d;
      sqy_q  <= sqy_d;
      rr_q   <= rr_d;
      oob2_q <= oob1_q;
      dist_q <= dist_d;
    end
  end

  assign valid_o = valid3_q;
  assign dist_o  = dist_q;

endmodule

FILE: design/rgcp_sqrt.sv
// Pipelined restoring square root of the squared distance scaled by 2^20.
// Depends on rgcp_pkg; two root bits are settled in each stage.
module rgcp_sqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  rgcp_pkg::rgcp_dist_t dist_i,
  output logic                 valid_o,
  output rgcp_pkg::rgcp_root_t root_o
);
  import rgcp_pkg::*;

  logic       valid_q [RootStages];
  rgcp_sqrt_t work_q  [RootStages];
  rgcp_dist_t dist_q  [RootStages];

  for (genvar g = 0; g < RootStages; g++) begin : gen_stage
    logic                 in_valid;
    rgcp_sqrt_t           in_work;
    rgcp_dist_t           in_dist;
    rgcp_sqrt_t           work_d;
    logic [2*RootW-1:0]   radicand;

    if (g == 0) begin : gen_first
      assign in_valid = valid_i;
      assign in_work  = '0;
      assign in_dist  = dist_i;
    end else begin : gen_next
      assign in_valid = valid_q[g-1];
      assign in_work  = work_q[g-1];
      assign in_dist  = dist_q[g-1];
    end

    assign radicand = {in_dist.d2, {(2 * RootW - D2W){1'b0}}};

    always_comb begin
      int step;
      work_d = in_work;
      for (int k = 0; k < StepsPerStage; k++) begin
        step = g * StepsPerStage + k;
        if (step < RootSteps) begin
          work_d = sqrt_step(work_d, radicand[2 * (RootSteps - 1 - step) +: 2]);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= in_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[g] <= work_d;
        dist_q[g] <= in_dist;
      end
    end
  end

  assign valid_o        = valid_q[RootStages-1];
  assign root_o.in_disc = dist_q[RootStages-1].in_disc;
  assign root_o.root    = work_q[RootStages-1].root;

endmodule

FILE: design/rgcp_div.sv
// Pipelined restoring divide of the scaled distance by the radius, giving t in unsigned Q1.10.
// Depends on rgcp_pkg; two quotient bits are settled in each stage but the last, which settles one.
module rgcp_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  rgcp_pkg::rgcp_root_t         root_i,
  input  logic [rgcp_pkg::RadiusW-1:0] radius_i,
  output logic                         valid_o,
  output rgcp_pkg::rgcp_ratio_t        ratio_o
);
  import rgcp_pkg::*;

  logic       valid_q [DivStages];
  rgcp_divw_t work_q  [DivStages];
  rgcp_root_t root_q  [DivStages];
  rgcp_divw_t last_work;

  for (genvar g = 0; g < DivStages; g++) begin : gen_stage
    logic       in_valid;
    rgcp_divw_t in_work;
    rgcp_root_t in_root;
    rgcp_divw_t work_d;

    if (g == 0) begin : gen_first
      assign in_valid    = valid_i;
      assign in_work.rem = RadiusW'(root_i.root >> TW);
      assign in_work.quo = '0;
      assign in_root     = root_i;
    end else begin : gen_next
      assign in_valid = valid_q[g-1];
      assign in_work  = work_q[g-1];
      assign in_root  = root_q[g-1];
    end

    always_comb begin
      int step;
      work_d = in_work;
      for (int k = 0; k < StepsPerStage; k++) begin
        step = g * StepsPerStage + k;
        if (step < DivSteps) begin
          work_d = div_step(work_d, in_root.root[DivSteps - 1 - step], radius_i);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= in_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[g] <= work_d;
        root_q[g] <= in_root;
      end
    end
  end

  assign last_work       = work_q[DivStages-1];
  assign valid_o         = valid_q[DivStages-1];
  assign ratio_o.in_disc = root_q[DivStages-1].in_disc;
  assign ratio_o.t       = (last_work.quo > TW'(UnitT)) ? TW'(UnitT) : last_work.quo;

endmodule

FILE: design/rgcp_shade.sv
// Two-stage color ramp: weight products, then sum, scale and outside masking.
// Depends on rgcp_pkg.
module rgcp_shade (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic                                        valid_i,
  input  rgcp_pkg::rgcp_ratio_t                       ratio_i,
  input  rgcp_pkg::rgcp_ramp_t [rgcp_pkg::NumChan-1:0] ramp_i,
  output logic                                        valid_o,
  output rgcp_pkg::rgcp_pix_t                         pix_o
);
  import rgcp_pkg::*;

  logic [TW-1:0]    wt;
  logic [ProdW-1:0] near_d  [NumChan];
  logic [ProdW-1:0] far_d   [NumChan];
  logic [ProdW-1:0] near_q  [NumChan];
  logic [ProdW-1:0] far_q   [NumChan];
  logic [ProdW-1:0] alpha_d, alpha_q;
  logic             inside_q;
  logic             valid1_q, valid2_q;
  logic [ProdW:0]   sum     [NumChan];
  rgcp_pix_t        pix_d, pix_q;

  assign wt      = TW'(UnitT) - ratio_i.t;
  assign alpha_d = ProdW'(AlphaMax) * ProdW'(wt);

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      near_d[c] = ProdW'(ramp_i[c].start) * ProdW'(wt);
      far_d[c]  = ProdW'(ramp_i[c].stop) * ProdW'(ratio_i.t);
    end
  end

  always_comb begin
    pix_d.in_disc = inside_q;
    for (int c = 0; c < NumChan; c++) begin
      sum[c]         = (ProdW + 1)'(near_q[c]) + (ProdW + 1)'(far_q[c]);
      pix_d.color[c] = inside_q ? sum[c][FracW +: ColorW] : '0;
    end
    pix_d.alpha = inside_q ? alpha_q[FracW +: ColorW] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      near_q   <= near_d;
      far_q    <= far_d;
      alpha_q  <= alpha_d;
      inside_q <= ratio_i.in_disc;
      pix_q    <= pix_d;
    end
  end

  assign valid_o = valid2_q;
  assign pix_o   = pix_q;

endmodule

FILE: design/rgcp_checker.sv
// Port-level checker for the radial gradient disc, bound to the top level.
// Depends on rgcp_pkg and radial_gradient_circle_pixel_macros.svh.
`include "radial_gradient_circle_pixel_macros.svh"

module rgcp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        inside_res_o,
  input logic [rgcp_pkg::ColorW-1:0] red_out_o,
  input logic [rgcp_pkg::ColorW-1:0] green_out_o,
  input logic [rgcp_pkg::ColorW-1:0] blue_out_o,
  input logic [rgcp_pkg::ColorW-1:0] alpha_out_o
);
  import rgcp_pkg::*;

  `RGCP_ASSERT(ast_outside_zero, out_valid_o && !inside_res_o,
    red_out_o == '0 && green_out_o == '0 && blue_out_o == '0 && alpha_out_o == '0,
    "Outside pixel carries a nonzero color.")
  `RGCP_ASSERT(ast_stall_has_result, in_stall_o, out_valid_o,
    "Input stalled with no result on the output.")
  `RGCP_ASSERT(ast_stall_cause, $rose(in_stall_o), $past(out_valid_o && out_stall_i),
    "Input stall rose without a blocked output transfer.")
  `RGCP_ASSERT_NEXT(ast_stall_release, in_stall_o && !out_stall_i, !in_stall_o,
    "Input stall held after the output transfer.")
  `RGCP_ASSERT_NEXT(ast_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(inside_res_o) && $stable(red_out_o) && $stable(alpha_out_o),
    "Stalled result changed.")

endmodule

bind radial_gradient_circle_pixel rgcp_checker u_rgcp_checker (.*);
